FILE: rtl/core/bbps_pkg.sv
// ----------------------------------------------------------------------------
// bbps_pkg
// Shared widths, codes and types for the basis blade product sign block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbps_pkg;

  // largest usable dimension, a larger dimension register is clipped to it
  localparam int MAX_DIM = 16;
  localparam int BLADE_W = 16;
  localparam int CNT_W   = 5;
  localparam int REQ_W   = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_GEOMETRIC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_OUTER     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REVERSE   = 2'd2;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_DEGENERATE = 2'd0;
  localparam logic [1:0] REG_POSITIVE   = 2'd1;
  localparam logic [1:0] REG_DIMENSION  = 2'd2;

  localparam logic [CNT_W-1:0] DEGENERATE_RST = 5'd1;
  localparam logic [CNT_W-1:0] POSITIVE_RST   = 5'd3;
  localparam logic [CNT_W-1:0] DIMENSION_RST  = 5'd4;

  typedef struct packed {
    logic [CNT_W-1:0] degenerate_count;
    logic [CNT_W-1:0] positive_count;
    logic [CNT_W-1:0] dimension;
  } bbps_cfg_t;

  typedef struct packed {
    logic               is_zero;
    logic               negative;
    logic [BLADE_W-1:0] result_blade;
  } bbps_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/bbps_if.sv
// ----------------------------------------------------------------------------
// bbps_req_if / bbps_rsp_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bbps_req_if
  import bbps_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [BLADE_W-1:0] lhs_blade;
  logic [BLADE_W-1:0] rhs_blade;

  modport source (output valid, output req_type, output lhs_blade, output rhs_blade,
                  input ready);
  modport sink (input valid, input req_type, input lhs_blade, input rhs_blade,
                output ready);
endinterface

interface bbps_rsp_if
  import bbps_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               is_zero;
  logic               negative;
  logic [BLADE_W-1:0] result_blade;

  modport source (output valid, output is_zero, output negative, output result_blade,
                  input ready);
  modport sink (input valid, input is_zero, input negative, input result_blade,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bbps_cfg.sv
// ----------------------------------------------------------------------------
// bbps_cfg
// APB register file holding the metric: degenerate, positive and dimension.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbps_cfg
  import bbps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output bbps_cfg_t              cfg
);

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.degenerate_count <= DEGENERATE_RST;
      cfg.positive_count   <= POSITIVE_RST;
      cfg.dimension        <= DIMENSION_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEGENERATE: cfg.degenerate_count <= pwdata[CNT_W-1:0];
        REG_POSITIVE:   cfg.positive_count   <= pwdata[CNT_W-1:0];
        REG_DIMENSION:  cfg.dimension        <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEGENERATE: prdata = DATA_W'(cfg.degenerate_count);
      REG_POSITIVE:   prdata = DATA_W'(cfg.positive_count);
      REG_DIMENSION:  prdata = DATA_W'(cfg.dimension);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/bbps_eval.sv
// ----------------------------------------------------------------------------
// bbps_eval
// Combinational sign, zero and blade evaluation for one registered request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbps_eval
  import bbps_pkg::*;
(
  input  wire bbps_cfg_t           cfg,
  input  wire logic [REQ_W-1:0]    req_type,
  input  wire logic [BLADE_W-1:0]  lhs_blade,
  input  wire logic [BLADE_W-1:0]  rhs_blade,
  output bbps_res_t                res
);

  logic [CNT_W-1:0]   dim_eff;
  logic [CNT_W:0]     neg_start;
  logic [BLADE_W-1:0] in_dim;
  logic [BLADE_W-1:0] geo_term;
  logic [BLADE_W-1:0] geo_zero;
  logic [BLADE_W-1:0] outer_term;
  logic [CNT_W-1:0]   pop;
  logic               geo_neg;
  logic               outer_neg;

  assign dim_eff   = (cfg.dimension > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : cfg.dimension;
  assign neg_start = {1'b0, cfg.degenerate_count} + {1'b0, cfg.positive_count};

  // per-index terms, each bit independent of the others
  always_comb begin
    for (int i = 0; i < BLADE_W; i++) begin
      in_dim[i]     = CNT_W'(i) < dim_eff;
      geo_term[i]   = in_dim[i] & lhs_blade[i] &
                      ((^(rhs_blade & ((BLADE_W'(1) << i) - BLADE_W'(1)))) ^
                       (rhs_blade[i] & ((CNT_W+1)'(i) >= neg_start)));
      geo_zero[i]   = in_dim[i] & lhs_blade[i] & rhs_blade[i] &
                      (CNT_W'(i) < cfg.degenerate_count);
      outer_term[i] = in_dim[i] & rhs_blade[i] & (^(lhs_blade >> (i + 1)));
    end
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < BLADE_W; i++) begin
      pop = pop + CNT_W'(lhs_blade[i]);
    end
  end

  assign geo_neg   = ^geo_term;
  assign outer_neg = ^outer_term;

  always_comb begin
    unique case (req_type)
      REQ_GEOMETRIC: begin
        res.is_zero      = |geo_zero;
        res.negative     = ~(|geo_zero) & geo_neg;
        res.result_blade = (|geo_zero) ? '0 : (lhs_blade ^ rhs_blade);
      end
      REQ_OUTER: begin
        res.is_zero      = |(lhs_blade & rhs_blade);
        res.negative     = ~(|(lhs_blade & rhs_blade)) & outer_neg;
        res.result_blade = (|(lhs_blade & rhs_blade)) ? '0 : (lhs_blade | rhs_blade);
      end
      REQ_REVERSE: begin
        res.is_zero      = 1'b0;
        res.negative     = pop[1];
        res.result_blade = lhs_blade;
      end
      default: begin
        res.is_zero      = 1'b1;
        res.negative     = 1'b0;
        res.result_blade = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/basis_blade_product_sign_top.sv
// ----------------------------------------------------------------------------
// basis_blade_product_sign_top
// Basis blade product unit: geometric, outer and reversion sign of bitmask
// blades under a programmable degenerate / positive / negative metric.
//
// usage:
//   req channel carries req_type, lhs_blade, rhs_blade; a transaction is
//   taken when valid and ready are both high. rsp channel returns is_zero,
//   negative and result_blade, one result per request, in order.
//   the metric lives in three APB registers at byte addresses 0, 4, 8
//   (degenerate_count, positive_count, dimension); write them only while
//   no request is in flight.
//   a request is held in the input register, then in the result register,
//   which drives rsp.valid; throughput is one transaction per cycle while
//   rsp is not stalled, set by the combinational evaluation logic between
//   the two registers.
//   when rsp is stalled, the result register holds and the input register
//   still takes one more request; req.ready drops only when both are full.
//   reset (rst, synchronous) empties both stages and restores the metric
//   to degenerate 1, positive 3, dimension 4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module basis_blade_product_sign_top
  import bbps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  bbps_req_if.sink               req,
  bbps_rsp_if.source             rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  bbps_cfg_t cfg;

  // input stage
  logic               s1_valid;
  logic [REQ_W-1:0]   s1_req_type;
  logic [BLADE_W-1:0] s1_lhs;
  logic [BLADE_W-1:0] s1_rhs;

  // result stage
  logic               s2_valid;
  bbps_res_t          s2_res;
  bbps_res_t          eval_res;

  logic               s2_open;
  logic               s1_move;

  bbps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result stage can load when empty or being drained this cycle
  assign s2_open   = ~s2_valid | rsp.ready;
  assign s1_move   = s1_valid & s2_open;
  assign req.ready = ~s1_valid | s2_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req_type <= req.req_type;
      s1_lhs      <= req.lhs_blade;
      s1_rhs      <= req.rhs_blade;
    end
  end

  bbps_eval u_eval (
    .cfg       (cfg),
    .req_type  (s1_req_type),
    .lhs_blade (s1_lhs),
    .rhs_blade (s1_rhs),
    .res       (eval_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_open) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_res <= eval_res;
    end
  end

  assign rsp.valid        = s2_valid;
  assign rsp.is_zero      = s2_res.is_zero;
  assign rsp.negative     = s2_res.negative;
  assign rsp.result_blade = s2_res.result_blade;

endmodule

`default_nettype wire

FILE: rtl/core/bbps_checker.sv
// ----------------------------------------------------------------------------
// bbps_checker
// Port-level checks on the result channel and flow control, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbps_checker
  import bbps_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic               rsp_is_zero,
  input wire logic               rsp_negative,
  input wire logic [BLADE_W-1:0] rsp_result_blade
);

  // stalled result holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_zero) &&
      $stable(rsp_negative) && $stable(rsp_result_blade))
    else $error("stalled result changed");

  // a vanishing product carries no sign and no blade
  a_zero_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_zero |-> !rsp_negative && (rsp_result_blade == '0))
    else $error("zero result with sign or blade");

  // with the result stage empty the block must take a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request blocked while output empty");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind basis_blade_product_sign_top bbps_checker u_bbps_checker (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_is_zero      (rsp.is_zero),
  .rsp_negative     (rsp.negative),
  .rsp_result_blade (rsp.result_blade)
);

`default_nettype wire

FILE: tb/bbps_tb_pkg.sv
// ----------------------------------------------------------------------------
// bbps_tb_pkg
// Blade product prediction and in-order result checking for the basis blade
// product sign testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbps_tb_pkg;
  import bbps_pkg::*;

  // request code with no operation behind it, answers a zero product
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  // register index that maps to nothing
  localparam logic [1:0]       REG_UNUSED = 2'd3;

  class blade_product_board;
    logic [CNT_W-1:0] degenerate_count;
    logic [CNT_W-1:0] positive_count;
    logic [CNT_W-1:0] dimension;
    bbps_res_t        pending_products[$];
    int unsigned      mismatches;
    int unsigned      failures;

    function new();
      degenerate_count = DEGENERATE_RST;
      positive_count   = POSITIVE_RST;
      dimension        = DIMENSION_RST;
      mismatches       = 0;
      failures         = 0;
    endfunction

    function void set_metric(logic [1:0] index, logic [CNT_W-1:0] value);
      case (index)
        REG_DEGENERATE: degenerate_count = value;
        REG_POSITIVE:   positive_count   = value;
        REG_DIMENSION:  dimension        = value;
        default: ;
      endcase
    endfunction

    function bbps_res_t blade_product(logic [REQ_W-1:0] kind, logic [BLADE_W-1:0] lhs,
                                      logic [BLADE_W-1:0] rhs);
      int unsigned span;
      int unsigned neg_start;
      int          i;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] bit_i;
      logic [31:0] above;
      logic [4:0]  ones;
      bbps_res_t   res;
      span      = (dimension > MAX_DIM) ? MAX_DIM : dimension;
      neg_start = degenerate_count + positive_count;
      a         = 32'(lhs);
      b         = 32'(rhs);
      res       = '0;
      case (kind)
        REQ_GEOMETRIC: begin
          for (i = 0; i < span; i++) begin
            bit_i = 32'h1 << i;
            if ((a & bit_i) != 0) begin
              // swaps past the lower rhs vectors
              res.negative ^= ^(b & (bit_i - 1));
              if ((b & bit_i) != 0) begin
                if (i < degenerate_count) begin
                  res.is_zero = 1'b1;
                end else if (i >= neg_start) begin
                  res.negative ^= 1'b1;
                end
              end
            end
          end
          res.result_blade = lhs ^ rhs;
        end
        REQ_OUTER: begin
          if ((a & b) != 0) begin
            res.is_zero = 1'b1;
          end else begin
            for (i = 0; i < span; i++) begin
              bit_i = 32'h1 << i;
              if ((b & bit_i) != 0) begin
                above = a & ~((bit_i << 1) - 1);
                res.negative ^= ^above;
              end
            end
            res.result_blade = lhs | rhs;
          end
        end
        REQ_REVERSE: begin
          ones             = 5'($countones(lhs));
          res.negative     = ones[1];
          res.result_blade = lhs;
        end
        default: res.is_zero = 1'b1;
      endcase
      if (res.is_zero) begin
        res.negative     = 1'b0;
        res.result_blade = '0;
      end
      return res;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [BLADE_W-1:0] lhs,
                               logic [BLADE_W-1:0] rhs);
      pending_products.push_back(blade_product(kind, lhs, rhs));
    endfunction

    function void check_product(logic is_zero, logic negative, logic [BLADE_W-1:0] blade);
      bbps_res_t want;
      if (pending_products.size() == 0) begin
        mismatches++;
        failures++;
        if (mismatches <= 10)
          $display("%0t: unexpected result zero=%0b neg=%0b blade=%04h",
                   $time, is_zero, negative, blade);
        return;
      end
      want = pending_products.pop_front();
      if (is_zero !== want.is_zero || negative !== want.negative ||
          blade !== want.result_blade) begin
        mismatches++;
        failures++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp z=%0b n=%0b b=%04h got z=%0b n=%0b b=%04h",
                   $time, want.is_zero, want.negative, want.result_blade,
                   is_zero, negative, blade);
      end
    endfunction

    function int unsigned outstanding();
      return pending_products.size();
    endfunction

    function void check_drained();
      if (pending_products.size() != 0) begin
        failures++;
        $display("%0t: %0d results never arrived", $time, pending_products.size());
      end
    endfunction
  endclass

endpackage

FILE: tb/basis_blade_product_sign_top_tb.sv
// ----------------------------------------------------------------------------
// basis_blade_product_sign_top_tb
// Drives geometric, outer, reversion and unused requests through the blade
// product unit under a range of metrics, predicts each result and checks the
// results in order, with random gaps on the request side and random stalls
// on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module basis_blade_product_sign_top_tb;
  import bbps_pkg::*;
  import bbps_tb_pkg::*;

  localparam int IDLE_PCT    = 31;    // chance in a hundred of a gap or a stall
  localparam int QUIET_LIMIT = 1000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 6;     // idle wait after the last drain
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 62;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              steady;        // no gaps and no stalls while set
  int unsigned       quiet_cycles;

  blade_product_board board;

  bbps_req_if req_ch ();
  bbps_rsp_if rsp_ch ();

  basis_blade_product_sign_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check the transaction taken at this edge, then pick the
  // ready for the next one
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_product(rsp_ch.is_zero, rsp_ch.negative, rsp_ch.result_blade);
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog: any request, result or register access counts as progress
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** basis_blade_product_sign_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one request and hold it until the unit takes it; valid stays
  // high afterwards so back-to-back requests need no extra edge
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [BLADE_W-1:0] lhs,
                              input logic [BLADE_W-1:0] rhs);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.lhs_blade <= lhs;
    req_ch.rhs_blade <= rhs;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(kind, lhs, rhs);
  endtask

  // random gap before a request, then the request itself
  task automatic offer(input logic [REQ_W-1:0] kind, input logic [BLADE_W-1:0] lhs,
                       input logic [BLADE_W-1:0] rhs);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    send_request(kind, lhs, rhs);
  endtask

  // stop sending and wait for every predicted result to come back
  task automatic drain_products();
    req_ch.valid <= 1'b0;
    while (board.outstanding() != 0)
      @(posedge clk);
  endtask

  // one register write: setup phase, then access phase until pready;
  // psel stays high so writes can follow back to back
  task automatic write_metric(input logic [1:0] index, input logic [CNT_W-1:0] value,
                              input logic [DATA_W-CNT_W-1:0] upper);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {upper, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_metric(index, value);
  endtask

  // load the whole metric; junk puts noise above the 5-bit fields and
  // also hits the unmapped register
  task automatic program_metric(input logic [CNT_W-1:0] degenerate,
                                input logic [CNT_W-1:0] positive,
                                input logic [CNT_W-1:0] dim, input bit junk);
    write_metric(REG_DEGENERATE, degenerate, junk ? (DATA_W-CNT_W)'($urandom) : '0);
    write_metric(REG_POSITIVE, positive, junk ? (DATA_W-CNT_W)'($urandom) : '0);
    write_metric(REG_DIMENSION, dim, junk ? (DATA_W-CNT_W)'($urandom) : '0);
    if (junk)
      write_metric(REG_UNUSED, CNT_W'($urandom), (DATA_W-CNT_W)'($urandom));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // blade shapes: anything, one or two vectors, only vectors inside the
  // dimension, nearly full, sparse
  function automatic logic [BLADE_W-1:0] random_blade();
    logic [BLADE_W-1:0] span_mask;
    int unsigned        span;
    span      = (board.dimension > MAX_DIM) ? MAX_DIM : board.dimension;
    span_mask = ~(16'hffff << span);
    case ($urandom_range(0, 4))
      0:       return BLADE_W'($urandom);
      1:       return (16'h1 << $urandom_range(0, 15)) | (16'h1 << $urandom_range(0, 15));
      2:       return BLADE_W'($urandom) & span_mask;
      3:       return 16'hffff ^ (16'h1 << $urandom_range(0, 15));
      default: return BLADE_W'($urandom & $urandom & $urandom);
    endcase
  endfunction

  task automatic random_request();
    int unsigned        pick;
    logic [REQ_W-1:0]   kind;
    logic [BLADE_W-1:0] lhs;
    logic [BLADE_W-1:0] rhs;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      kind = REQ_GEOMETRIC;
    else if (pick < 75)
      kind = REQ_OUTER;
    else if (pick < 95)
      kind = REQ_REVERSE;
    else
      kind = REQ_UNUSED;
    lhs = random_blade();
    rhs = random_blade();
    // half the outer products get disjoint blades so the sign path runs
    if (kind == REQ_OUTER && $urandom_range(0, 1) == 1)
      rhs = rhs & ~lhs;
    offer(kind, lhs, rhs);
  endtask

  initial begin
    board            = new();
    rst              = 1'b1;
    steady           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_GEOMETRIC;
    req_ch.lhs_blade = '0;
    req_ch.rhs_blade = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset metric: one degenerate, three positive, dimension four
    offer(REQ_GEOMETRIC, 16'h0000, 16'h0000);
    offer(REQ_GEOMETRIC, 16'hffff, 16'hffff);   // shared degenerate vector
    offer(REQ_GEOMETRIC, 16'h0002, 16'h0001);   // one swap
    offer(REQ_GEOMETRIC, 16'h0001, 16'h0002);
    offer(REQ_GEOMETRIC, 16'h0006, 16'h0006);
    offer(REQ_GEOMETRIC, 16'h0030, 16'h0010);   // vectors above the dimension
    offer(REQ_OUTER, 16'h0001, 16'h0001);       // overlap
    offer(REQ_OUTER, 16'h0004, 16'h0003);
    offer(REQ_OUTER, 16'h8000, 16'h0001);       // lhs above dimension still counts
    offer(REQ_OUTER, 16'h0000, 16'hffff);
    offer(REQ_REVERSE, 16'h0007, 16'h0000);
    offer(REQ_REVERSE, 16'hffff, 16'h0000);
    offer(REQ_REVERSE, 16'h0000, 16'hffff);     // rhs ignored
    offer(REQ_UNUSED, 16'hffff, 16'hffff);

    // every vector squares to minus one
    drain_products();
    program_metric(5'd0, 5'd0, 5'd16, 1'b0);
    offer(REQ_GEOMETRIC, 16'h0001, 16'h0001);
    offer(REQ_GEOMETRIC, 16'hffff, 16'hffff);
    offer(REQ_GEOMETRIC, 16'h8000, 16'h8000);
    offer(REQ_REVERSE, 16'h000c, 16'h5555);

    // all degenerate, dimension beyond the limit, noise on the bus
    drain_products();
    program_metric(5'd16, 5'd0, 5'd31, 1'b1);
    offer(REQ_GEOMETRIC, 16'h8000, 16'h8000);
    offer(REQ_GEOMETRIC, 16'h8000, 16'h7fff);
    offer(REQ_OUTER, 16'h7fff, 16'h8000);

    // one positive vector, two negative, and a vector above the dimension
    drain_products();
    program_metric(5'd0, 5'd1, 5'd3, 1'b0);
    offer(REQ_GEOMETRIC, 16'h0007, 16'h0007);
    offer(REQ_GEOMETRIC, 16'h0008, 16'h0008);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_products();
      case (phase)
        0:       program_metric(5'd0, 5'd0, 5'd0, 1'b0);
        1:       program_metric(5'd16, 5'd16, 5'd16, 1'b0);
        2:       program_metric(5'd31, 5'd31, 5'd31, 1'b1);
        default: program_metric(CNT_W'($urandom_range(0, 16)), CNT_W'($urandom_range(0, 16)),
                                CNT_W'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
      endcase
      // one phase runs flat out on both sides
      steady <= (phase == 4);
      repeat (PHASE_ITEMS) begin
        random_request();
        // now and then let the whole pipeline empty before going on
        if ($urandom_range(0, 49) == 0)
          drain_products();
      end
    end

    drain_products();
    repeat (TAIL_CYCLES) @(posedge clk);
    board.check_drained();
    if (board.failures == 0) begin
      $display("** basis_blade_product_sign_top: PASSED **");
    end else begin
      $display("** basis_blade_product_sign_top: FAILED **");
    end
    $finish;
  end

endmodule
